FILE: design/lkrb_pkg.sv
// shared types and constants of the layered keyboard report builder
`timescale 1ns / 1ps
`default_nettype none
package lkrb_pkg;

  localparam int VIS_SLOTS = 6;

  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_MAPW = 2'd1;
  localparam logic [1:0] OP_SYNC = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_ROLL     = 3'd1;
  localparam logic [2:0] REG_LAYER1   = 3'd2;
  localparam logic [2:0] REG_LAYER2   = 3'd3;
  localparam logic [2:0] REG_FUNCTION = 3'd4;
  localparam logic [2:0] REG_NO_KEY   = 3'd5;

  localparam logic [1:0] MODE_RST     = 2'd0;
  localparam logic       ROLL_RST     = 1'b1;
  localparam logic [7:0] LAYER1_RST   = 8'd240;
  localparam logic [7:0] LAYER2_RST   = 8'd241;
  localparam logic [7:0] FUNCTION_RST = 8'd242;
  localparam logic [7:0] NO_KEY_RST   = 8'd0;

  localparam logic [7:0] ROLL_CODE  = 8'h01;
  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef logic [VIS_SLOTS:0][7:0] report_t;

  typedef struct packed {
    logic accept;
    logic look;
    logic run;
    logic base;
    logic sweep_clear;
    logic layer_wr;
    logic layer_val;
    logic flag_sel;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic key_go;
    logic down;
    logic hit_l1;
    logic hit_l2;
    logic hit_fn;
    logic found;
    logic done;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: design/lkrb_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lkrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 384
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

FILE: design/lkrb_ctrl.sv
// controller state machine of the report builder
`timescale 1ns / 1ps
`default_nettype none
module lkrb_ctrl import lkrb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_HOLD   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       sel_r, sel_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.flag_sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = start;
        if (start && sts.key_go) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        sel_nxt      = sts.hit_l2;
        cmd.flag_sel = sts.hit_l2;
        if (sts.hit_l1 || sts.hit_l2) begin
          cmd.sweep_clear = 1'b1;
          if (sts.down) begin
            cmd.layer_wr  = 1'b1;
            cmd.layer_val = 1'b1;
            state_nxt     = S_SCAN;
          end else begin
            state_nxt = S_HOLD;
          end
        end else if (sts.hit_fn) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.sweep_clear = 1'b1;
          state_nxt       = S_SCAN;
        end
      end
      S_HOLD: begin
        cmd.run  = 1'b1;
        cmd.base = 1'b1;
        if (sts.found) begin
          state_nxt = S_IDLE;
        end else if (sts.done) begin
          cmd.layer_wr    = 1'b1;
          cmd.layer_val   = 1'b0;
          cmd.sweep_clear = 1'b1;
          state_nxt       = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.run = 1'b1;
        if (sts.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/lkrb_dp.sv
// datapath: config registers, key bitmap, mapping tables, scan and report
`timescale 1ns / 1ps
`default_nettype none
module lkrb_dp import lkrb_pkg::*; #(
  parameter int KEYS  = 128,
  parameter int SLOTS = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dp_cmd_t    cmd,
  output dp_sts_t         sts,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_key_index,
  input  wire logic       in_pressed,
  input  wire logic [1:0] in_map_layer,
  input  wire logic [7:0] in_hid_code,
  input  wire logic       cfg_wr,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output logic            out_valid,
  output report_t         report
);

  localparam int AW = $clog2(3 * KEYS);
  localparam int CW = $clog2(KEYS + 1);
  localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam logic [AW-1:0] OFF1 = AW'(KEYS);
  localparam logic [AW-1:0] OFF2 = AW'(2 * KEYS);

  logic [1:0] mode_r;
  logic       roll_r;
  logic [7:0] l1_r, l2_r, fn_r, nk_r;

  logic [KEYS-1:0] pmap_r;
  logic            second_r, third_r;
  logic [KW-1:0]   key_r;
  logic            down_r;
  logic [CW-1:0]   cnt_r;
  logic            rd_vld_r;
  logic [KW-1:0]   idx_r;
  logic            found_r;
  logic [7:0]      mod_r;
  logic [7:0]      slot_r [SLOTS];
  logic [7:0]      slot_nxt [SLOTS];
  logic            over_r, over_nxt;
  report_t         last_r;
  logic            valid_r;

  logic          key_ok;
  logic [1:0]    act_layer;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data;
  logic          issue;
  logic          eval_hit;
  logic [7:0]    target;
  logic          skip_code, is_mod;
  logic [SLOTS-1:0] eq_v, zero_v;
  report_t       rep;

  function automatic logic [AW-1:0] lay_off(input logic [1:0] lay);
    logic [AW-1:0] off;
    unique case (lay)
      2'd0:    off = '0;
      2'd1:    off = OFF1;
      default: off = OFF2;
    endcase
    return off;
  endfunction

  assign key_ok    = ({1'b0, in_key_index} < 9'(KEYS));
  assign act_layer = third_r ? 2'd2 : (second_r ? 2'd1 : 2'd0);
  assign wr_en     = cmd.accept && (in_opcode == OP_MAPW) && key_ok && (in_map_layer != 2'd3);
  assign wr_addr   = lay_off(in_map_layer) + AW'(in_key_index[KW-1:0]);
  assign issue     = cmd.run && !cmd.sweep_clear && (cnt_r < CW'(KEYS));

  always_comb begin
    if (cmd.look) begin
      rd_addr = lay_off(act_layer) + AW'(key_r);
    end else if (cmd.base) begin
      rd_addr = AW'(cnt_r);
    end else begin
      rd_addr = lay_off(act_layer) + AW'(cnt_r);
    end
  end

  lkrb_ram #(
    .WIDTH(8),
    .DEPTH(3 * KEYS)
  ) u_tables (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_hid_code),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign sts.key_go = (in_opcode == OP_KEY) && key_ok && !mode_r[1];
  assign sts.down   = down_r;
  assign sts.hit_l1 = (rd_data == l1_r);
  assign sts.hit_l2 = (rd_data != l1_r) && (rd_data == l2_r);
  assign sts.hit_fn = (rd_data == fn_r);
  assign sts.found  = found_r;
  assign sts.done   = (cnt_r == CW'(KEYS)) && !rd_vld_r;

  assign eval_hit  = cmd.run && rd_vld_r && pmap_r[idx_r];
  assign target    = cmd.flag_sel ? l2_r : l1_r;
  assign skip_code = (rd_data == l1_r) || (rd_data == l2_r) || (rd_data == fn_r) ||
                     (rd_data == nk_r);
  assign is_mod    = (rd_data[7:3] == MOD_PREFIX);

  // slot placement of one scanned key
  always_comb begin
    logic taken;
    taken    = 1'b0;
    over_nxt = over_r;
    for (int j = 0; j < SLOTS; j++) begin
      eq_v[j]     = (slot_r[j] == rd_data);
      zero_v[j]   = (slot_r[j] == 8'd0);
      slot_nxt[j] = slot_r[j];
    end
    if (eval_hit && !cmd.base && !skip_code && !is_mod && !(|eq_v)) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (zero_v[j] && !taken) begin
          slot_nxt[j] = rd_data;
          taken       = 1'b1;
        end
      end
      if (!taken) begin
        over_nxt = 1'b1;
      end
    end
  end

  assign rep[0] = mod_r;
  for (genvar v = 0; v < VIS_SLOTS; v++) begin : g_vis
    if (v < SLOTS) begin : g_used
      assign rep[v+1] = (over_r && roll_r) ? ROLL_CODE : slot_r[v];
    end else begin : g_unused
      assign rep[v+1] = 8'd0;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RST;
      roll_r <= ROLL_RST;
      l1_r   <= LAYER1_RST;
      l2_r   <= LAYER2_RST;
      fn_r   <= FUNCTION_RST;
      nk_r   <= NO_KEY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_MODE:     mode_r <= cfg_data[1:0];
        REG_ROLL:     roll_r <= cfg_data[0];
        REG_LAYER1:   l1_r   <= cfg_data;
        REG_LAYER2:   l2_r   <= cfg_data;
        REG_FUNCTION: fn_r   <= cfg_data;
        REG_NO_KEY:   nk_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // key and layer state, report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmap_r   <= '0;
      second_r <= 1'b0;
      third_r  <= 1'b0;
      last_r   <= '0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= (cmd.accept && (in_opcode == OP_SYNC)) || (cmd.finish && (rep != last_r));
      if (cmd.accept && (in_opcode == OP_SYNC)) begin
        pmap_r   <= '0;
        second_r <= 1'b0;
        third_r  <= 1'b0;
        last_r   <= '0;
      end else if (cmd.accept && (in_opcode == OP_KEY) && key_ok) begin
        pmap_r[in_key_index[KW-1:0]] <= in_pressed;
      end
      if (cmd.layer_wr) begin
        if (cmd.flag_sel) begin
          third_r <= cmd.layer_val;
        end else begin
          second_r <= cmd.layer_val;
        end
      end
      if (cmd.finish && (rep != last_r)) begin
        last_r <= rep;
      end
    end
  end

  // sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      over_r   <= 1'b0;
    end else if (cmd.sweep_clear) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      over_r   <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (eval_hit && cmd.base && (rd_data == target) && (idx_r != key_r)) begin
        found_r <= 1'b1;
      end
      over_r <= over_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r  <= in_key_index[KW-1:0];
      down_r <= in_pressed;
    end
    idx_r <= cnt_r[KW-1:0];
    if (cmd.sweep_clear) begin
      mod_r <= 8'd0;
      for (int j = 0; j < SLOTS; j++) begin
        slot_r[j] <= 8'd0;
      end
    end else begin
      if (eval_hit && !cmd.base && !skip_code && is_mod) begin
        mod_r <= mod_r | (8'd1 << rd_data[2:0]);
      end
      for (int j = 0; j < SLOTS; j++) begin
        slot_r[j] <= slot_nxt[j];
      end
    end
  end

  assign out_valid = valid_r;
  assign report    = last_r;

endmodule
`default_nettype wire

FILE: design/layered_keyboard_report_builder_top.sv
// top level of the layered keyboard report builder
//
// channels: an input transaction is taken at a clock edge with start high and
// busy low; in_opcode selects key event, mapping write or resync. a report
// leaves on the out_ ports for one cycle with out_valid high and cannot be
// held off. config registers are written over cfg_valid/cfg_index/cfg_data,
// cfg_ready is always high; write them only while the block is idle.
// mapping writes finish in the accept cycle, busy stays low.
// resync strobes an all-zero report in the cycle after accept.
// a key event in mode 0 or 1 reads its own mapping, then, unless that is
// the function code, sweeps all KEYS entries of the active layer table,
// one ram read per cycle, and builds a report. releasing a layer key
// first sweeps the base table for other held keys of that kind and ends
// there, keeping the layer, if one is found.
// a key event's report leaves only when it differs from the last one sent.
// reset clears key bitmap, layer flags, last report, sets config defaults;
// mapping tables keep their content and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module layered_keyboard_report_builder_top import lkrb_pkg::*; #(
  parameter int KEYS  = 128,
  parameter int SLOTS = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_key_index,
  input  wire logic       in_pressed,
  input  wire logic [1:0] in_map_layer,
  input  wire logic [7:0] in_hid_code,
  output logic            out_valid,
  output logic [7:0]      out_modifier_bits,
  output logic [7:0]      out_slot_zero,
  output logic [7:0]      out_slot_one,
  output logic [7:0]      out_slot_two,
  output logic [7:0]      out_slot_three,
  output logic [7:0]      out_slot_four,
  output logic [7:0]      out_slot_five,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  report_t report;

  assign cfg_ready = 1'b1;

  lkrb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  lkrb_dp #(
    .KEYS  (KEYS),
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (in_opcode),
    .in_key_index (in_key_index),
    .in_pressed   (in_pressed),
    .in_map_layer (in_map_layer),
    .in_hid_code  (in_hid_code),
    .cfg_wr       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .report       (report)
  );

  assign out_modifier_bits = report[0];
  assign out_slot_zero     = report[1];
  assign out_slot_one      = report[2];
  assign out_slot_two      = report[3];
  assign out_slot_three    = report[4];
  assign out_slot_four     = report[5];
  assign out_slot_five     = report[6];

endmodule
`default_nettype wire

FILE: sim/tb_layered_keyboard_report_builder_top.sv
// self-checking testbench for the layered keyboard report builder top level
`timescale 1ns / 1ps
module tb_layered_keyboard_report_builder_top;
  import lkrb_pkg::*;

  localparam int KEYS = 128;
  localparam int SLOTS = 6;
  localparam int TAIL_CYCLES = 2 * KEYS + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOT_KEYS = 8;
  localparam int LOADED_KEYS = 16;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_MOUSE = 2'd1;
  localparam logic [1:0] MODE_RACE = 2'd2;
  localparam logic [1:0] MODE_THREE = 2'd3;
  localparam logic [1:0] LAYER_BASE = 2'd0;
  localparam logic [1:0] LAYER_THIRD = 2'd2;
  localparam logic [1:0] LAYER_BAD = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = 2'd0;
  logic [7:0] in_key_index = 8'd0;
  logic in_pressed = 1'b0;
  logic [1:0] in_map_layer = 2'd0;
  logic [7:0] in_hid_code = 8'd0;
  logic out_valid;
  logic [7:0] out_modifier_bits;
  logic [7:0] out_slot_zero;
  logic [7:0] out_slot_one;
  logic [7:0] out_slot_two;
  logic [7:0] out_slot_three;
  logic [7:0] out_slot_four;
  logic [7:0] out_slot_five;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_data = 8'd0;

  // predicted block state
  logic [1:0] m_mode;
  logic m_rollover;
  logic [7:0] m_layer1_code;
  logic [7:0] m_layer2_code;
  logic [7:0] m_function_code;
  logic [7:0] m_no_key_code;
  logic [KEYS-1:0] held_keys;
  logic layer2_active;
  logic layer3_active;
  logic [7:0] key_map [0:3*KEYS-1];
  logic [2:0] layers_written [0:KEYS-1];
  report_t sent_report;

  report_t expected_reports[$];
  int hot_key [0:HOT_KEYS-1];
  int sender_idle_pct = 0;
  int mismatch_count = 0;
  int reports_checked = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  layered_keyboard_report_builder_top #(
    .KEYS (KEYS),
    .SLOTS(SLOTS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_key_index     (in_key_index),
    .in_pressed       (in_pressed),
    .in_map_layer     (in_map_layer),
    .in_hid_code      (in_hid_code),
    .out_valid        (out_valid),
    .out_modifier_bits(out_modifier_bits),
    .out_slot_zero    (out_slot_zero),
    .out_slot_one     (out_slot_one),
    .out_slot_two     (out_slot_two),
    .out_slot_three   (out_slot_three),
    .out_slot_four    (out_slot_four),
    .out_slot_five    (out_slot_five),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] mapped_code(input int k);
    int layer;
    layer = layer3_active ? 2 : (layer2_active ? 1 : 0);
    return key_map[layer * KEYS + k];
  endfunction

  function automatic logic other_layer_key_held(input int k, input logic [7:0] code);
    logic held;
    held = 1'b0;
    for (int i = 0; i < KEYS; i++) begin
      if (i != k && key_map[i] == code && held_keys[i]) held = 1'b1;
    end
    return held;
  endfunction

  function automatic report_t rescan_report();
    report_t rep;
    logic [7:0] slot_codes [0:SLOTS-1];
    logic [7:0] c;
    logic overflow;
    logic seen;
    logic placed;
    rep = '0;
    overflow = 1'b0;
    for (int i = 0; i < SLOTS; i++) slot_codes[i] = 8'h00;
    for (int k = 0; k < KEYS; k++) begin
      if (!held_keys[k]) continue;
      c = mapped_code(k);
      if (c == m_layer1_code || c == m_layer2_code || c == m_function_code ||
          c == m_no_key_code) continue;
      if (c[7:3] == MOD_PREFIX) begin
        rep[0][c[2:0]] = 1'b1;
        continue;
      end
      seen = 1'b0;
      for (int i = 0; i < SLOTS; i++) if (slot_codes[i] == c) seen = 1'b1;
      if (!seen) begin
        placed = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && slot_codes[i] == 8'h00) begin
            slot_codes[i] = c;
            placed = 1'b1;
          end
        end
        if (!placed) overflow = 1'b1;
      end
    end
    if (overflow && m_rollover) begin
      for (int i = 0; i < SLOTS; i++) slot_codes[i] = ROLL_CODE;
    end
    for (int i = 0; i < VIS_SLOTS && i < SLOTS; i++) rep[i+1] = slot_codes[i];
    return rep;
  endfunction

  function automatic void predict_keyboard_item(input logic [1:0] op, input logic [7:0] key,
                                                input logic down, input logic [1:0] ml,
                                                input logic [7:0] hc);
    report_t rep;
    logic [7:0] c;
    logic rescan;
    int k;
    k = int'(key);
    case (op)
      OP_MAPW: begin
        if (k < KEYS && ml != LAYER_BAD) begin
          key_map[int'(ml) * KEYS + k] = hc;
          layers_written[k][ml] = 1'b1;
        end
      end
      OP_SYNC: begin
        held_keys = '0;
        layer2_active = 1'b0;
        layer3_active = 1'b0;
        sent_report = '0;
        expected_reports.push_back(sent_report);
      end
      OP_KEY: begin
        if (k < KEYS) begin
          held_keys[k] = down;
          if (m_mode < MODE_RACE) begin
            rescan = 1'b1;
            c = mapped_code(k);
            if (c == m_layer1_code) begin
              if (!down && other_layer_key_held(k, m_layer1_code)) rescan = 1'b0;
              else layer2_active = down;
            end else if (c == m_layer2_code) begin
              if (!down && other_layer_key_held(k, m_layer2_code)) rescan = 1'b0;
              else layer3_active = down;
            end else if (c == m_function_code) begin
              rescan = 1'b0;
            end
            if (rescan) begin
              rep = rescan_report();
              if (rep != sent_report) begin
                sent_report = rep;
                expected_reports.push_back(rep);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    int r;
    logic [7:0] v;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      v = 8'($urandom_range(0, 11));
      return 8'h04 + v;
    end
    if (r < 60) begin
      v = 8'($urandom_range(0, 7));
      return 8'hE0 + v;
    end
    if (r < 66) return m_layer1_code;
    if (r < 71) return m_layer2_code;
    if (r < 75) return m_function_code;
    if (r < 82) return m_no_key_code;
    v = 8'($urandom_range(0, 255));
    return v;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] key, input logic down,
                           input logic [1:0] ml, input logic [7:0] hc);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_key_index <= key;
    in_pressed <= down;
    in_map_layer <= ml;
    in_hid_code <= hc;
    do @(posedge clk); while (busy !== 1'b0);
    predict_keyboard_item(op, key, down, ml, hc);
    items_sent++;
  endtask

  task automatic key_event(input int k, input logic down);
    send_item(OP_KEY, k[7:0], down, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_MODE:     m_mode = data[1:0];
      REG_ROLL:     m_rollover = data[0];
      REG_LAYER1:   m_layer1_code = data;
      REG_LAYER2:   m_layer2_code = data;
      REG_FUNCTION: m_function_code = data;
      REG_NO_KEY:   m_no_key_code = data;
      default: begin
      end
    endcase
    cfg_writes++;
  endtask

  task automatic apply_config(input logic [1:0] md, input logic roll, input logic [7:0] l1,
                              input logic [7:0] l2, input logic [7:0] fn, input logic [7:0] nk);
    quiesce();
    write_register(REG_MODE, {6'd0, md});
    write_register(REG_ROLL, {7'd0, roll});
    write_register(REG_LAYER1, l1);
    write_register(REG_LAYER2, l2);
    write_register(REG_FUNCTION, fn);
    write_register(REG_NO_KEY, nk);
    cfg_valid <= 1'b0;
  endtask

  // picks a small set of keys to play on and remaps them for the current codes
  task automatic run_random(input int count, input int sync_pct);
    int done;
    int sel;
    int k;
    logic down;
    logic [1:0] ml;
    hot_key[0] = 0;
    hot_key[1] = KEYS - 1;
    for (int i = 2; i < HOT_KEYS; i++) hot_key[i] = $urandom_range(0, KEYS - 1);
    for (int i = 0; i < HOT_KEYS; i++) begin
      for (int layer = 0; layer < 3; layer++) begin
        k = hot_key[i];
        send_item(OP_MAPW, k[7:0], 1'($urandom_range(0, 1)), layer[1:0], pick_code());
      end
    end
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 99) < 3) begin
        start <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < sync_pct) begin
        send_item(OP_SYNC, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        done++;
      end else if (sel < sync_pct + 10) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(KEYS, 255) :
            $urandom_range(0, KEYS - 1);
        ml = ($urandom_range(0, 19) == 0) ? LAYER_BAD : 2'($urandom_range(0, 2));
        send_item(OP_MAPW, k[7:0], 1'($urandom_range(0, 1)), ml, pick_code());
        if (k < KEYS && ml != LAYER_BAD) done++;
      end else if (sel < sync_pct + 12) begin
        send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 88) begin
          k = hot_key[$urandom_range(0, HOT_KEYS - 1)];
        end else if (sel < 94) begin
          k = $urandom_range(0, KEYS - 1);
          if (layers_written[k] != 3'b111) k = hot_key[$urandom_range(0, HOT_KEYS - 1)];
        end else begin
          k = $urandom_range(KEYS, 255);
        end
        if (k < KEYS && held_keys[k]) down = ($urandom_range(0, 3) == 0);
        else down = ($urandom_range(0, 3) != 0);
        key_event(k, down);
        if (k < KEYS) done++;
      end
    end
  endtask

  task automatic test_table_load();
    logic [7:0] code;
    int k;
    for (int layer = 0; layer < 3; layer++) begin
      for (int n = 0; n <= LOADED_KEYS; n++) begin
        k = (n < LOADED_KEYS) ? n : KEYS - 1;
        code = pick_code();
        if (layer == 0) begin
          case (k)
            0, 1, 2, 3, 4, 5, 6, 7: code = 8'h04 + k[7:0];
            8:       code = 8'hE0;
            9:       code = 8'hE7;
            10, 11:  code = LAYER1_RST;
            12:      code = LAYER2_RST;
            13:      code = FUNCTION_RST;
            14:      code = NO_KEY_RST;
            15:      code = 8'h04;
            default: begin
            end
          endcase
        end else if (layer == 1) begin
          if (k == 0) code = 8'h1E;
          if (k == 10 || k == 11) code = LAYER1_RST;
        end else begin
          if (k == 0) code = 8'h1F;
          if (k == 12) code = LAYER2_RST;
        end
        send_item(OP_MAPW, k[7:0], 1'($urandom_range(0, 1)), layer[1:0], code);
      end
    end
  endtask

  task automatic test_directed_events();
    key_event(0, 1'b1);
    key_event(8, 1'b1);
    key_event(9, 1'b1);
    // duplicate code, no-key code and fn key leave the report alone
    key_event(15, 1'b1);
    key_event(14, 1'b1);
    key_event(13, 1'b1);
    for (int k = 1; k <= 6; k++) key_event(k, 1'b1);
    key_event(KEYS - 1, 1'b1);
    key_event(KEYS, 1'b1);
    key_event(255, 1'b0);
    send_item(OP_UNUSED, 8'hFF, 1'b1, LAYER_BAD, 8'hFF);
    send_item(OP_MAPW, 8'd0, 1'b0, LAYER_BAD, 8'h00);
    send_item(OP_MAPW, 8'd200, 1'b1, LAYER_BASE, 8'hFF);
    send_item(OP_SYNC, 8'd0, 1'b0, LAYER_BASE, 8'h00);
    key_event(0, 1'b1);
    // two layer keys of one kind: first release is held off
    key_event(10, 1'b1);
    key_event(11, 1'b1);
    key_event(10, 1'b0);
    key_event(11, 1'b0);
    key_event(12, 1'b1);
    key_event(12, 1'b0);
    send_item(OP_SYNC, 8'hFF, 1'b1, LAYER_THIRD, 8'hFF);
  endtask

  task automatic test_default_config();
    apply_config(MODE_NORMAL, 1'b1, LAYER1_RST, LAYER2_RST, FUNCTION_RST, NO_KEY_RST);
    sender_idle_pct = 28;
    run_random(25, 4);
  endtask

  task automatic test_extreme_codes();
    apply_config(MODE_MOUSE, 1'b0, 8'hFF, 8'h00, 8'h80, 8'hFF);
    sender_idle_pct = 28;
    run_random(25, 4);
  endtask

  task automatic test_equal_layer_codes();
    apply_config(MODE_NORMAL, 1'b1, 8'h30, 8'h30, 8'h31, 8'h32);
    sender_idle_pct = 28;
    run_random(25, 4);
  endtask

  task automatic test_race_mode();
    apply_config(MODE_RACE, 1'b1, LAYER1_RST, LAYER2_RST, FUNCTION_RST, NO_KEY_RST);
    sender_idle_pct = 88;
    run_random(25, 25);
  endtask

  task automatic test_modifier_layer_codes();
    apply_config(MODE_MOUSE, 1'b1, 8'hE0, 8'hE7, 8'hFF, 8'h04);
    sender_idle_pct = 88;
    run_random(25, 4);
  endtask

  task automatic test_mode_three();
    apply_config(MODE_THREE, 1'b0, LAYER1_RST, LAYER2_RST, FUNCTION_RST, NO_KEY_RST);
    sender_idle_pct = 88;
    run_random(20, 25);
  endtask

  task automatic test_back_to_back();
    apply_config(MODE_NORMAL, 1'b1, 8'h01, 8'h02, 8'h00, 8'h05);
    sender_idle_pct = 0;
    run_random(25, 4);
  endtask

  // result checker: every strobed report against the oldest prediction
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = {out_slot_five, out_slot_four, out_slot_three, out_slot_two, out_slot_one,
             out_slot_zero, out_modifier_bits};
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected report %014h with nothing predicted", got);
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        for (int f = 0; f <= VIS_SLOTS; f++) begin
          if (got[f] !== want[f]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("report %0d byte %0d (0 = modifiers): expected %02h, got %02h",
                       reports_checked, f, want[f], got[f]);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    m_mode = MODE_RST;
    m_rollover = ROLL_RST;
    m_layer1_code = LAYER1_RST;
    m_layer2_code = LAYER2_RST;
    m_function_code = FUNCTION_RST;
    m_no_key_code = NO_KEY_RST;
    held_keys = '0;
    layer2_active = 1'b0;
    layer3_active = 1'b0;
    sent_report = '0;
    for (int i = 0; i < 3 * KEYS; i++) key_map[i] = 8'h00;
    for (int i = 0; i < KEYS; i++) layers_written[i] = 3'b000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_directed_events();
    test_default_config();
    test_extreme_codes();
    test_equal_layer_codes();
    test_race_mode();
    test_modifier_layer_codes();
    test_mode_three();
    test_back_to_back();
    quiesce();
    $display("covered %0d transactions over seven register settings, %0d register writes",
             items_sent, cfg_writes);
    $display("checked %0d reports, %0d mismatches", reports_checked, mismatch_count);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
